// ----- rtl/arfe_pkg.sv -----
// arfe_pkg: shared types, command and status codes and the feedback table
// for the audio ring feedback engine
// no dependencies; imported by every rtl file of the block
package arfe_pkg;

    // default ring depth in stereo frames
    localparam int RING_FRAMES_DEF = 256;

    // payload widths fixed by the stream format
    localparam int SAMPLE_W = 32;
    localparam int PAIR_W   = 2 * SAMPLE_W;
    localparam int FILL_W   = 9;
    localparam int SPEED_W  = 2;
    localparam int RATE_W   = 3;

    typedef logic [1:0]          t_cmd;
    typedef logic [1:0]          t_status;
    typedef logic [SPEED_W-1:0]  t_speed;
    typedef logic [RATE_W-1:0]   t_rate;
    typedef logic [SAMPLE_W-1:0] t_word;

    // item commands
    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_PLAY  = 2'd1;
    localparam t_cmd CMD_EOP   = 2'd2;
    localparam t_cmd CMD_RESET = 2'd3;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_DROP  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RESET = 2'd3;

    // speed codes, two's complement
    localparam t_speed SPEED_SLOW = 2'b11;
    localparam t_speed SPEED_NOM  = 2'b00;
    localparam t_speed SPEED_FAST = 2'b01;

    // highest rate code that has a feedback entry
    localparam t_rate RATE_LAST_FB = 3'd5;

    // swap the two halfwords of a sample word
    function automatic t_word swap_halves(t_word v);
        return {v[15:0], v[31:16]};
    endfunction

    // 16.16 samples per microframe; the nominal entry is floor(rate_tenths_khz * 65536 / 80)
    function automatic t_word feedback_lut(t_rate rate, t_speed speed);
        t_word fb;
        fb = '0;
        case (rate)
            3'd0: begin
                fb = (speed == SPEED_FAST) ? 32'd367820 :
                     (speed == SPEED_SLOW) ? 32'd354713 : 32'd361267;
            end
            3'd1: begin
                fb = (speed == SPEED_FAST) ? 32'd400588 :
                     (speed == SPEED_SLOW) ? 32'd385843 : 32'd393216;
            end
            3'd2: begin
                fb = (speed == SPEED_FAST) ? 32'd729907 :
                     (speed == SPEED_SLOW) ? 32'd714342 : 32'd722534;
            end
            3'd3: begin
                fb = (speed == SPEED_FAST) ? 32'd794624 :
                     (speed == SPEED_SLOW) ? 32'd778240 : 32'd786432;
            end
            3'd4: begin
                fb = (speed == SPEED_FAST) ? 32'd1452441 :
                     (speed == SPEED_SLOW) ? 32'd1436876 : 32'd1445068;
            end
            3'd5: begin
                fb = (speed == SPEED_FAST) ? 32'd1581056 :
                     (speed == SPEED_SLOW) ? 32'd1564672 : 32'd1572864;
            end
            default: begin
                fb = '0;
            end
        endcase
        return fb;
    endfunction

endpackage

// ----- rtl/arfe_ring_mem.sv -----
// arfe_ring_mem: stereo frame ring storage, one write port and one
// registered read port; depends on arfe_pkg for the pair width
module arfe_ring_mem #(
    parameter int DEPTH = arfe_pkg::RING_FRAMES_DEF,
    parameter int AW    = $clog2(arfe_pkg::RING_FRAMES_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [arfe_pkg::PAIR_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [arfe_pkg::PAIR_W-1:0] o_rd_data
);
    import arfe_pkg::*;

    logic [PAIR_W-1:0] r_mem [DEPTH];
    logic [PAIR_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/audio_ring_feedback_engine.sv -----
// audio_ring_feedback_engine: stereo elastic ring with rate feedback, top level
// depends on arfe_pkg and arfe_ring_mem

// Takes one item per clock cycle unless the output stalls; each result enters
// the output register as its item is accepted, and a new item is accepted in the
// same cycle the previous result is taken. A play item reads its pair from the
// registered read port of the ring memory, so the popped samples arrive with the
// rest of the result. Write items not dropped store their pair as they are
// accepted. The ring needs no clearing pass after reset: a play only ever reads
// slots already written. rate_code is written over the always-ready cfg channel;
// write it only while the stream is idle (not enforced). It takes effect at the
// next end-of-packet item; codes 6 and 7 leave the feedback word as it was.
module audio_ring_feedback_engine #(
    parameter int RING_FRAMES = arfe_pkg::RING_FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [arfe_pkg::RATE_W-1:0]   i_cfg_data,    // rate_code
    // input item stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,       // left_in, right_in
    input  logic [1:0]                    s_tuser,       // command
    // result item stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // left_out, right_out, feedback_word, fill_level, speed_code, playing, pad
    output logic [111:0]                  m_tdata,
    output logic [1:0]                    m_tuser        // status
);
    import arfe_pkg::*;

    localparam int IW  = $clog2(RING_FRAMES);
    localparam int FW1 = IW + 1;
    localparam logic [IW-1:0] IDX_LAST   = IW'(RING_FRAMES - 1);
    localparam logic [IW:0]   RING_N     = FW1'(RING_FRAMES);
    localparam logic [IW:0]   HALF_FILL  = FW1'(RING_FRAMES / 2);
    localparam logic [IW:0]   FULL_FILL  = FW1'(RING_FRAMES / 3 * 2);

    // state
    logic [IW-1:0]     r_wr_idx, n_wr_idx;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_play, n_play;
    logic              r_drop, n_drop;
    logic [31:0]       r_ovr_cnt, n_ovr_cnt;
    t_word             r_fb, n_fb;
    t_speed            r_speed, n_speed;
    t_rate             r_rate;

    // result register
    logic              r_m_valid;
    t_status           r_status, n_status;
    logic              r_pop, n_pop;
    logic [FILL_W-1:0] r_fill;

    // item decode and ring access
    logic              w_s_acc;
    t_cmd              w_cmd;
    logic [IW-1:0]     w_wr_next;
    logic [IW-1:0]     w_rd_next;
    logic [IW-1:0]     w_fill_cur;
    logic [IW-1:0]     w_fill_nxt;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [PAIR_W-1:0] w_wr_pair;
    logic [PAIR_W-1:0] w_rd_pair;
    logic [PAIR_W-1:0] w_out_pair;

    // frames held, (w - r) mod RING_FRAMES
    function automatic logic [IW-1:0] ring_fill(logic [IW-1:0] w, logic [IW-1:0] r);
        logic [IW:0] diff;
        logic [IW:0] wrapped;
        diff    = {1'b0, w} - {1'b0, r};
        wrapped = diff + RING_N;
        return (w >= r) ? diff[IW-1:0] : wrapped[IW-1:0];
    endfunction

    assign w_s_acc     = s_tvalid && s_tready;
    assign s_tready    = !r_m_valid || m_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cmd       = s_tuser;

    assign w_wr_next  = (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + 1'b1;
    assign w_rd_next  = (r_rd_idx == IDX_LAST) ? '0 : r_rd_idx + 1'b1;
    assign w_fill_cur = ring_fill(r_wr_idx, r_rd_idx);
    assign w_fill_nxt = ring_fill(n_wr_idx, n_rd_idx);
    assign w_wr_pair  = {swap_halves(s_tdata[63:32]), swap_halves(s_tdata[31:0])};

    // next state for the accepted item
    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_play    = r_play;
        n_drop    = r_drop;
        n_ovr_cnt = r_ovr_cnt;
        n_fb      = r_fb;
        n_speed   = r_speed;
        n_status  = ST_OK;
        n_pop     = 1'b0;
        w_mem_we  = 1'b0;
        w_mem_re  = 1'b0;
        unique case (w_cmd)
            CMD_WRITE: begin
                if (r_drop) begin
                    n_status = ST_DROP;
                end else if (w_wr_next == r_rd_idx) begin
                    n_ovr_cnt = r_ovr_cnt + 32'd1;
                    n_drop    = 1'b1;
                    n_status  = ST_DROP;
                end else begin
                    n_wr_idx = w_wr_next;
                    w_mem_we = w_s_acc;
                end
            end
            CMD_PLAY: begin
                if (r_rd_idx == r_wr_idx) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd_idx = w_rd_next;
                    n_pop    = 1'b1;
                    w_mem_re = w_s_acc;
                end
            end
            CMD_EOP: begin
                n_drop = 1'b0;
                if ({1'b0, w_fill_cur} > HALF_FILL) begin
                    n_play = 1'b1;
                end
                if ({1'b0, w_fill_cur} > FULL_FILL) begin
                    n_speed = SPEED_SLOW;
                end else if ({1'b0, w_fill_cur} > HALF_FILL) begin
                    n_speed = SPEED_NOM;
                end else begin
                    n_speed = SPEED_FAST;
                end
                if (r_rate <= RATE_LAST_FB) begin
                    n_fb = feedback_lut(r_rate, n_speed);
                end
            end
            CMD_RESET: begin
                n_wr_idx = '0;
                n_rd_idx = '0;
                n_play   = 1'b0;
                n_drop   = 1'b0;
                n_status = ST_RESET;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // control state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_play    <= 1'b0;
            r_drop    <= 1'b0;
            r_ovr_cnt <= '0;
            r_fb      <= '0;
            r_speed   <= SPEED_NOM;
            r_rate    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_rate <= i_cfg_data;
            end
            if (w_s_acc) begin
                r_wr_idx  <= n_wr_idx;
                r_rd_idx  <= n_rd_idx;
                r_play    <= n_play;
                r_drop    <= n_drop;
                r_ovr_cnt <= n_ovr_cnt;
                r_fb      <= n_fb;
                r_speed   <= n_speed;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_status <= n_status;
            r_pop    <= n_pop;
            r_fill   <= FILL_W'(w_fill_nxt);
        end
    end

    // ring storage
    arfe_ring_mem #(
        .DEPTH (RING_FRAMES),
        .AW    (IW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_wr_next),
        .i_wr_data (w_wr_pair),
        .i_rd_en   (w_mem_re),
        .i_rd_addr (w_rd_next),
        .o_rd_data (w_rd_pair)
    );

    // output packing
    assign w_out_pair = r_pop ? w_rd_pair : '0;
    assign m_tvalid   = r_m_valid;
    assign m_tuser    = r_status;
    assign m_tdata    = {4'b0000, r_play, r_speed, r_fill, r_fb, w_out_pair};

`ifndef ASSERT_OFF
    // a reset stream item leaves an empty ring and stopped playback
    a_reset_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_cmd == CMD_RESET) |=> (r_wr_idx == '0 && r_rd_idx == '0 && !r_play))
        else $error("reset stream did not clear ring pointers");

    // an empty play result carries zero samples
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[63:0] == '0))
        else $error("empty play returned samples");

    // playback only stops through a reset stream item
    a_play_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_play) && $past(i_rst_n)) |-> $past(w_s_acc && w_cmd == CMD_RESET))
        else $error("playback stopped without reset stream");
`endif

endmodule
